// ----- rtl/mmpla_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpla_pkg
// Shared types for the memory-map PLA decoder: raw pin levels and select flags.
// ----------------------------------------------------------------------------
package mmpla_pkg;

  typedef struct packed {
    logic [3:0] cpu_addr_top;
    logic [2:0] vic_addr_top;
    logic       cas_level;
    logic       loram_level;
    logic       hiram_level;
    logic       charen_level;
    logic       game_level;
    logic       exrom_level;
    logic       bus_available;
    logic       aec_level;
    logic       read_not_write;
  } pla_pins_t;

  typedef struct packed {
    logic basic_sel;
    logic kernal_sel;
    logic charom_sel;
    logic io_sel;
    logic roml_sel;
    logic romh_sel;
    logic gated_write;
    logic ram_cas;
  } pla_sel_t;

endpackage

// ----- rtl/mmpla_decode.sv -----
// ----------------------------------------------------------------------------
// mmpla_decode
// Product-term array and OR planes: raw pin levels to eight select flags.
// ----------------------------------------------------------------------------
module mmpla_decode (
  input  mmpla_pkg::pla_pins_t pins,
  output mmpla_pkg::pla_sel_t  sel
);
  import mmpla_pkg::*;

  logic a12, a13, a14, a15;
  logic va12, va13, va14;
  logic cas, loram, hiram, charen, game, exrom, ba, aec, rw;
  logic dblk, ultimax, nogame, rd_ba;
  logic [31:0] p;
  logic basic, kernal, charom, io, roml, romh, blocked;

  always_comb begin
    a12    = pins.cpu_addr_top[0];
    a13    = pins.cpu_addr_top[1];
    a14    = pins.cpu_addr_top[2];
    a15    = pins.cpu_addr_top[3];
    va12   = pins.vic_addr_top[0];
    va13   = pins.vic_addr_top[1];
    va14   = ~pins.vic_addr_top[2];
    cas    = ~pins.cas_level;
    loram  = ~pins.loram_level;
    hiram  = ~pins.hiram_level;
    charen = ~pins.charen_level;
    game   = ~pins.game_level;
    exrom  = ~pins.exrom_level;
    ba     = pins.bus_available;
    aec    = ~pins.aec_level;
    rw     = pins.read_not_write;

    dblk    = a15 & a14 & ~a13 & a12 & ~aec;
    ultimax = exrom & ~game;
    nogame  = ~exrom & ~game;
    rd_ba   = ba & rw;

    p[0]  = loram & hiram & a15 & ~a14 & a13 & ~aec & rw & game;
    p[1]  = hiram & a15 & a14 & a13 & ~aec & rw & game;
    p[2]  = hiram & a15 & a14 & a13 & ~aec & rw & nogame;
    p[3]  = hiram & ~charen & dblk & rw & game;
    p[4]  = loram & ~charen & dblk & rw & game;
    p[5]  = hiram & ~charen & dblk & rw & nogame;
    p[6]  = va14 & ~va13 & va12 & aec & game;
    p[7]  = va14 & ~va13 & va12 & aec & nogame;
    p[8]  = cas & dblk & ~rw;
    p[9]  = hiram & charen & dblk & rd_ba & game;
    p[10] = hiram & charen & dblk & ~rw & game;
    p[11] = loram & charen & dblk & rd_ba & game;
    p[12] = loram & charen & dblk & ~rw & game;
    p[13] = hiram & charen & dblk & rd_ba & nogame;
    p[14] = hiram & charen & dblk & ~rw & nogame;
    p[15] = loram & charen & dblk & rd_ba & nogame;
    p[16] = loram & charen & dblk & ~rw & nogame;
    p[17] = dblk & rd_ba & ultimax;
    p[18] = dblk & ~rw & ultimax;
    p[19] = loram & hiram & a15 & ~a14 & ~a13 & ~aec & rw & ~exrom;
    p[20] = a15 & ~a14 & ~a13 & ~aec & ultimax;
    p[21] = hiram & a15 & ~a14 & a13 & ~aec & rw & nogame;
    p[22] = a15 & a14 & a13 & ~aec & ultimax;
    p[23] = va13 & va12 & aec & ultimax;
    p[24] = ~a15 & ~a14 & a12 & ultimax;
    p[25] = ~a15 & ~a14 & a13 & ultimax;
    p[26] = ~a15 & a14 & ultimax;
    p[27] = a15 & ~a14 & a13 & ultimax;
    p[28] = a15 & a14 & ~a13 & ~a12 & ultimax;
    p[29] = ~cas;
    p[30] = cas;
    p[31] = ~cas & dblk & ~rw;

    basic   = p[0];
    kernal  = |p[2:1];
    charom  = |p[7:3];
    io      = |p[18:9];
    roml    = |p[20:19];
    romh    = |p[23:21];
    blocked = basic | kernal | charom | io | roml | romh | (|p[28:24]);

    sel.basic_sel   = basic;
    sel.kernal_sel  = kernal;
    sel.charom_sel  = charom;
    sel.io_sel      = io;
    sel.roml_sel    = roml;
    sel.romh_sel    = romh;
    sel.gated_write = p[31];
    sel.ram_cas     = p[30] & ~blocked & (p[8] | ~p[8]) & (p[29] | ~p[29]);
  end

endmodule

// ----- rtl/memory_map_pla_decoder_top.sv -----
// ----------------------------------------------------------------------------
// memory_map_pla_decoder_top
// Memory-map PLA decoder with a registered input stage and a result register.
// Path: input register pins_r, combinational decode, then result register sel_r.
// Throughput: one item per cycle; the input stage keeps taking items while a
// result waits, until both stages hold data.
// Reset: synchronous active-low rst_n clears both stage valid flags.
// ----------------------------------------------------------------------------
module memory_map_pla_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_cpu_addr_top,
  input  logic [2:0] in_vic_addr_top,
  input  logic       in_cas_level,
  input  logic       in_loram_level,
  input  logic       in_hiram_level,
  input  logic       in_charen_level,
  input  logic       in_game_level,
  input  logic       in_exrom_level,
  input  logic       in_bus_available,
  input  logic       in_aec_level,
  input  logic       in_read_not_write,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_basic_sel,
  output logic       out_kernal_sel,
  output logic       out_charom_sel,
  output logic       out_io_sel,
  output logic       out_roml_sel,
  output logic       out_romh_sel,
  output logic       out_gated_write,
  output logic       out_ram_cas
);
  import mmpla_pkg::*;

  pla_pins_t pins_r;
  logic      pins_vld_r;
  pla_sel_t  sel_nxt;
  pla_sel_t  sel_r;
  logic      sel_vld_r;
  logic      res_adv;

  assign res_adv  = ~sel_vld_r | out_ready;
  assign in_ready = ~pins_vld_r | res_adv;

  mmpla_decode u_decode (
    .pins (pins_r),
    .sel  (sel_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_vld_r <= 1'b0;
      sel_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        pins_vld_r <= in_valid;
      end
      if (res_adv) begin
        sel_vld_r <= pins_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pins_r.cpu_addr_top   <= in_cpu_addr_top;
      pins_r.vic_addr_top   <= in_vic_addr_top;
      pins_r.cas_level      <= in_cas_level;
      pins_r.loram_level    <= in_loram_level;
      pins_r.hiram_level    <= in_hiram_level;
      pins_r.charen_level   <= in_charen_level;
      pins_r.game_level     <= in_game_level;
      pins_r.exrom_level    <= in_exrom_level;
      pins_r.bus_available  <= in_bus_available;
      pins_r.aec_level      <= in_aec_level;
      pins_r.read_not_write <= in_read_not_write;
    end
    if (res_adv && pins_vld_r) begin
      sel_r <= sel_nxt;
    end
  end

  assign out_valid       = sel_vld_r;
  assign out_basic_sel   = sel_r.basic_sel;
  assign out_kernal_sel  = sel_r.kernal_sel;
  assign out_charom_sel  = sel_r.charom_sel;
  assign out_io_sel      = sel_r.io_sel;
  assign out_roml_sel    = sel_r.roml_sel;
  assign out_romh_sel    = sel_r.romh_sel;
  assign out_gated_write = sel_r.gated_write;
  assign out_ram_cas     = sel_r.ram_cas;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (pins_vld_r && sel_vld_r))
    else $error("input stalled with a free stage");

  a_cas_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_ram_cas && out_gated_write))
    else $error("ram_cas and gated_write both set");

  a_io_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_io_sel || out_basic_sel || out_kernal_sel)) |-> !out_ram_cas)
    else $error("ram_cas set over a ROM or I/O select");

  a_pipe_move: assert property (@(posedge clk) disable iff (!rst_n)
    (pins_vld_r && res_adv) |=> sel_vld_r)
    else $error("staged item not moved to result register");

endmodule
